// ----- hdl/stma_pkg.sv -----
// ============================================================================
// stma_pkg: shared types and constants for the sparse triplet merge-add unit
// Entry layout, list sizing, command, status and register codes.
// ============================================================================
package stma_pkg;

    // List sizing
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Configuration port sizing
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register indexes (selected by paddr[2])
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    // Commands
    localparam logic [1:0] CMD_CLEAR       = 2'd0;
    localparam logic [1:0] CMD_LOAD_FIRST  = 2'd1;
    localparam logic [1:0] CMD_LOAD_SECOND = 2'd2;
    localparam logic [1:0] CMD_MERGE       = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_RANGE = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    // One stored triplet
    typedef struct packed {
        logic [15:0]        row;
        logic [15:0]        col;
        logic signed [31:0] val;
    } entry_t;

    // Write request into one list memory
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           entry;
    } list_wr_t;

endpackage

// ----- hdl/stma_ifs.sv -----
// ============================================================================
// stma interfaces: valid/ready channels of the merge-add unit
// Input word channel and result word channel, each with source/sink views.
// ============================================================================
interface stma_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [15:0]        row_index;
    logic [15:0]        column_index;
    logic signed [31:0] entry_value;

    modport source (
        output valid, command, row_index, column_index, entry_value,
        input  ready
    );
    modport sink (
        input  valid, command, row_index, column_index, entry_value,
        output ready
    );
endinterface

interface stma_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [15:0]        out_row;
    logic [15:0]        out_column;
    logic signed [32:0] out_value;
    logic               last;

    modport source (
        output valid, status, out_row, out_column, out_value, last,
        input  ready
    );
    modport sink (
        input  valid, status, out_row, out_column, out_value, last,
        output ready
    );
endinterface

// ----- hdl/stma_list.sv -----
// ============================================================================
// stma_list: triplet list storage
// One write port and one synchronous read port whose read word is registered.
// ============================================================================
module stma_list (
    input  logic                     clk,
    input  stma_pkg::list_wr_t       wr,
    input  logic [stma_pkg::IDX_W-1:0] rd_addr,
    output stma_pkg::entry_t         rd_entry
);

    stma_pkg::entry_t mem [stma_pkg::MAX_ENTRIES];
    stma_pkg::entry_t rd_entry_reg;

    // Store a loaded triplet
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.entry;
        end
    end

    // Register the read word
    always_ff @(posedge clk)
    begin
        rd_entry_reg <= mem[rd_addr];
    end

    assign rd_entry = rd_entry_reg;

endmodule

// ----- hdl/sparse_triplet_merge_add_unit.sv -----
// ============================================================================
// sparse_triplet_merge_add_unit: sum of two sparse matrices in triplet form
// Loads, clears and merge-adds two triplet lists held in on-chip memory.
// ============================================================================
// A clear or a load returns one status word. A merge walks both lists one step
// per cycle while the result sink does not stall, through the single read port
// of each list memory and one shared key compare and 33-bit adder: one step per
// entry of either list, a coincident pair being one step, then one closing step.
// No item is accepted during a merge. The last surviving sum word carries last; a
// merge with no survivor returns one empty-status word. Loads are not order
// checked. No clearing pass follows reset.
module sparse_triplet_merge_add_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stma_pkg::ADDR_W-1:0]   paddr,
    input  logic [stma_pkg::DATA_W-1:0]   pwdata,
    output logic [stma_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    stma_item_if.sink                     item,
    stma_result_if.source                 result
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_MERGE = 1'b1;

    localparam int CW = stma_pkg::CNT_W;
    localparam int IW = stma_pkg::IDX_W;

    // Control state
    logic          state_reg, state_next;
    logic [CW-1:0] first_cnt_reg, first_cnt_next;
    logic [CW-1:0] second_cnt_reg, second_cnt_next;
    logic [CW-1:0] a_reg, a_next;
    logic [CW-1:0] b_reg, b_next;
    logic [15:0]   row_count_reg, column_count_reg;
    logic          res_vld_reg, res_vld_next;
    logic          pend_vld_reg, pend_vld_next;

    // Result and pending payload
    logic [2:0]         res_status_reg, res_status_next;
    logic [15:0]        res_row_reg, res_row_next;
    logic [15:0]        res_col_reg, res_col_next;
    logic signed [32:0] res_val_reg, res_val_next;
    logic               res_last_reg, res_last_next;
    logic [15:0]        pend_row_reg, pend_row_next;
    logic [15:0]        pend_col_reg, pend_col_next;
    logic signed [32:0] pend_val_reg, pend_val_next;

    // Memory ports
    stma_pkg::list_wr_t wr_first, wr_second;
    stma_pkg::entry_t   rd_a, rd_b;

    // Handshake and merge datapath
    logic               out_free, item_fire, step_fire, cfg_wr;
    logic               a_has, b_has, done;
    logic               take_a, take_b, cand_emit;
    logic [31:0]        key_a, key_b;
    logic signed [32:0] sum_val;
    logic [15:0]        cand_row, cand_col;
    logic signed [32:0] cand_val;
    logic               range_bad, list_full;
    logic [CW-1:0]      load_cnt;
    logic [2:0]         load_status;
    stma_pkg::entry_t   load_entry;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= 16'hFFFF;
            column_count_reg <= 16'hFFFF;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                stma_pkg::REG_ROW_COUNT:    row_count_reg    <= pwdata[15:0];
                stma_pkg::REG_COLUMN_COUNT: column_count_reg <= pwdata[15:0];
                default:                    row_count_reg    <= row_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            stma_pkg::REG_ROW_COUNT:    prdata = {16'd0, row_count_reg};
            stma_pkg::REG_COLUMN_COUNT: prdata = {16'd0, column_count_reg};
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // List memories, read at the next walk position
    // ------------------------------------------------------------------
    stma_list u_first (
        .clk      (clk),
        .wr       (wr_first),
        .rd_addr  (a_next[IW-1:0]),
        .rd_entry (rd_a)
    );

    stma_list u_second (
        .clk      (clk),
        .wr       (wr_second),
        .rd_addr  (b_next[IW-1:0]),
        .rd_entry (rd_b)
    );

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign out_free   = !res_vld_reg || result.ready;
    assign item.ready = (state_reg == S_IDLE) && out_free;
    assign item_fire  = item.valid && item.ready;
    assign step_fire  = (state_reg == S_MERGE) && out_free;

    // ------------------------------------------------------------------
    // Load checks
    // ------------------------------------------------------------------
    assign load_cnt  = (item.command == stma_pkg::CMD_LOAD_FIRST) ? first_cnt_reg
                                                                   : second_cnt_reg;
    assign range_bad = (item.row_index >= row_count_reg) ||
                       (item.column_index >= column_count_reg);
    assign list_full = (load_cnt >= CW'(stma_pkg::MAX_ENTRIES));

    always_comb
    begin
        priority if (range_bad)
            load_status = stma_pkg::ST_RANGE;
        else if (list_full)
            load_status = stma_pkg::ST_FULL;
        else
            load_status = stma_pkg::ST_OK;
    end

    assign load_entry = '{row: item.row_index, col: item.column_index,
                          val: item.entry_value};

    // ------------------------------------------------------------------
    // Merge step: compare heads, pick or sum
    // ------------------------------------------------------------------
    assign a_has   = (a_reg < first_cnt_reg);
    assign b_has   = (b_reg < second_cnt_reg);
    assign done    = !a_has && !b_has;
    assign key_a   = {rd_a.row, rd_a.col};
    assign key_b   = {rd_b.row, rd_b.col};
    assign sum_val = $signed({rd_a.val[31], rd_a.val}) +
                     $signed({rd_b.val[31], rd_b.val});

    always_comb
    begin
        take_a    = 1'b0;
        take_b    = 1'b0;
        cand_emit = 1'b1;
        cand_row  = rd_a.row;
        cand_col  = rd_a.col;
        cand_val  = $signed({rd_a.val[31], rd_a.val});
        priority if (a_has && b_has)
        begin
            priority if (key_a > key_b)
            begin
                take_b   = 1'b1;
                cand_row = rd_b.row;
                cand_col = rd_b.col;
                cand_val = $signed({rd_b.val[31], rd_b.val});
            end
            else if (key_a < key_b)
            begin
                take_a = 1'b1;
            end
            else
            begin
                take_a    = 1'b1;
                take_b    = 1'b1;
                cand_val  = sum_val;
                cand_emit = (sum_val != 33'sd0);
            end
        end
        else if (a_has)
        begin
            take_a = 1'b1;
        end
        else if (b_has)
        begin
            take_b   = 1'b1;
            cand_row = rd_b.row;
            cand_col = rd_b.col;
            cand_val = $signed({rd_b.val[31], rd_b.val});
        end
        else
        begin
            cand_emit = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        res_vld_next    = res_vld_reg;
        res_status_next = res_status_reg;
        res_row_next    = res_row_reg;
        res_col_next    = res_col_reg;
        res_val_next    = res_val_reg;
        res_last_next   = res_last_reg;
        pend_vld_next   = pend_vld_reg;
        pend_row_next   = pend_row_reg;
        pend_col_next   = pend_col_reg;
        pend_val_next   = pend_val_reg;
        wr_first        = '{en: 1'b0, addr: first_cnt_reg[IW-1:0], entry: load_entry};
        wr_second       = '{en: 1'b0, addr: second_cnt_reg[IW-1:0], entry: load_entry};

        // Drop the result word once taken
        if (res_vld_reg && result.ready)
        begin
            res_vld_next = 1'b0;
        end

        if (item_fire)
        begin
            // Status word for clear and loads
            res_vld_next    = 1'b1;
            res_status_next = stma_pkg::ST_OK;
            res_row_next    = '0;
            res_col_next    = '0;
            res_val_next    = '0;
            res_last_next   = 1'b1;
            unique case (item.command)
                stma_pkg::CMD_CLEAR:
                begin
                    first_cnt_next  = '0;
                    second_cnt_next = '0;
                end
                stma_pkg::CMD_LOAD_FIRST:
                begin
                    res_status_next = load_status;
                    if (load_status == stma_pkg::ST_OK)
                    begin
                        wr_first.en    = 1'b1;
                        first_cnt_next = first_cnt_reg + CW'(1);
                    end
                end
                stma_pkg::CMD_LOAD_SECOND:
                begin
                    res_status_next = load_status;
                    if (load_status == stma_pkg::ST_OK)
                    begin
                        wr_second.en    = 1'b1;
                        second_cnt_next = second_cnt_reg + CW'(1);
                    end
                end
                stma_pkg::CMD_MERGE:
                begin
                    res_vld_next  = res_vld_reg && !result.ready;
                    state_next    = S_MERGE;
                    a_next        = '0;
                    b_next        = '0;
                    pend_vld_next = 1'b0;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
        else if (step_fire)
        begin
            if (done)
            begin
                // Close the run: flush the held entry or report empty
                res_vld_next  = 1'b1;
                res_last_next = 1'b1;
                if (pend_vld_reg)
                begin
                    res_status_next = stma_pkg::ST_SUM;
                    res_row_next    = pend_row_reg;
                    res_col_next    = pend_col_reg;
                    res_val_next    = pend_val_reg;
                end
                else
                begin
                    res_status_next = stma_pkg::ST_EMPTY;
                    res_row_next    = '0;
                    res_col_next    = '0;
                    res_val_next    = '0;
                end
                pend_vld_next = 1'b0;
                state_next    = S_IDLE;
            end
            else
            begin
                // Advance heads; hold one entry back so the final one gets last
                if (take_a)
                begin
                    a_next = a_reg + CW'(1);
                end
                if (take_b)
                begin
                    b_next = b_reg + CW'(1);
                end
                if (cand_emit)
                begin
                    if (pend_vld_reg)
                    begin
                        res_vld_next    = 1'b1;
                        res_status_next = stma_pkg::ST_SUM;
                        res_row_next    = pend_row_reg;
                        res_col_next    = pend_col_reg;
                        res_val_next    = pend_val_reg;
                        res_last_next   = 1'b0;
                    end
                    pend_vld_next = 1'b1;
                    pend_row_next = cand_row;
                    pend_col_next = cand_col;
                    pend_val_next = cand_val;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            res_vld_reg    <= 1'b0;
            pend_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            a_reg          <= a_next;
            b_reg          <= b_next;
            res_vld_reg    <= res_vld_next;
            pend_vld_reg   <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_row_reg    <= res_row_next;
        res_col_reg    <= res_col_next;
        res_val_reg    <= res_val_next;
        res_last_reg   <= res_last_next;
        pend_row_reg   <= pend_row_next;
        pend_col_reg   <= pend_col_next;
        pend_val_reg   <= pend_val_next;
    end

    // Result channel
    assign result.valid      = res_vld_reg;
    assign result.status     = res_status_reg;
    assign result.out_row    = res_row_reg;
    assign result.out_column = res_col_reg;
    assign result.out_value  = res_val_reg;
    assign result.last       = res_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_walk_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |-> ((a_reg <= first_cnt_reg) && (b_reg <= second_cnt_reg)))
        else $error("merge walk position beyond list fill");

    a_count_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (first_cnt_reg <= CW'(stma_pkg::MAX_ENTRIES)) &&
        (second_cnt_reg <= CW'(stma_pkg::MAX_ENTRIES)))
        else $error("list fill count beyond capacity");

    a_close_flags_last: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && done) |=> (res_vld_reg && res_last_reg && (state_reg == S_IDLE)))
        else $error("merge run closed without a last word");

endmodule

// ----- verif/sparse_triplet_merge_add_unit_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sparse_triplet_merge_add_unit_tb: self-checking bench for the merge-add unit
// Loads triplet lists, clears them and runs merges through the word channels.
// Register changes go over the APB port between phases. Every result word is
// compared with a local prediction of the list state and the merge walk.
// ============================================================================
module sparse_triplet_merge_add_unit_tb;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    // One line of the directed table
    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  cmd;
        logic        reg_sel;
        logic [15:0] row;
        logic [15:0] col;
        logic [31:0] val;
        logic [7:0]  reps;
        logic        typed;
        logic [2:0]  status;
    } plan_row_t;

    // One result word as seen on the result channel
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] row;
        logic [15:0] col;
        logic [32:0] value;
        logic        last;
    } result_word_t;

    localparam int PLAN_ROWS = 26;
    localparam int BATCH_MAX = 18;

    localparam plan_row_t PLAN [0:PLAN_ROWS-1] = '{
        '{ROW_WORD, stma_pkg::CMD_MERGE, 1'b0, 16'd0, 16'd0, 32'd0,
          8'd1, 1'b1, stma_pkg::ST_EMPTY},
        '{ROW_WORD, stma_pkg::CMD_LOAD_FIRST, 1'b0, 16'd0, 16'd0, 32'h8000_0000,
          8'd1, 1'b1, stma_pkg::ST_OK},
        '{ROW_WORD, stma_pkg::CMD_LOAD_SECOND, 1'b0, 16'd0, 16'd0, 32'h8000_0000,
          8'd1, 1'b1, stma_pkg::ST_OK},
        '{ROW_WORD, stma_pkg::CMD_LOAD_FIRST, 1'b0, 16'd65535, 16'd0, 32'd3,
          8'd1, 1'b1, stma_pkg::ST_RANGE},
        '{ROW_WORD, stma_pkg::CMD_LOAD_SECOND, 1'b0, 16'd0, 16'd65535, 32'd3,
          8'd1, 1'b1, stma_pkg::ST_RANGE},
        '{ROW_WORD, stma_pkg::CMD_LOAD_FIRST, 1'b0, 16'd65534, 16'd65534, 32'h7FFF_FFFF,
          8'd1, 1'b1, stma_pkg::ST_OK},
        '{ROW_WORD, stma_pkg::CMD_LOAD_SECOND, 1'b0, 16'd65534, 16'd65534, 32'h7FFF_FFFF,
          8'd1, 1'b1, stma_pkg::ST_OK},
        '{ROW_WORD, stma_pkg::CMD_MERGE, 1'b0, 16'd0, 16'd0, 32'd0,
          8'd1, 1'b0, stma_pkg::ST_OK},
        '{ROW_WORD, stma_pkg::CMD_CLEAR, 1'b0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
          8'd1, 1'b1, stma_pkg::ST_OK},
        '{ROW_WORD, stma_pkg::CMD_LOAD_FIRST, 1'b0, 16'd2, 16'd3, 32'd5,
          8'd1, 1'b1, stma_pkg::ST_OK},
        '{ROW_WORD, stma_pkg::CMD_LOAD_SECOND, 1'b0, 16'd2, 16'd3, 32'hFFFF_FFFB,
          8'd1, 1'b1, stma_pkg::ST_OK},
        '{ROW_WORD, stma_pkg::CMD_LOAD_SECOND, 1'b0, 16'd4, 16'd0, 32'd9,
          8'd1, 1'b1, stma_pkg::ST_OK},
        '{ROW_WORD, stma_pkg::CMD_LOAD_FIRST, 1'b0, 16'd1, 16'd7, 32'hFFFF_FFFF,
          8'd1, 1'b1, stma_pkg::ST_OK},
        '{ROW_WORD, stma_pkg::CMD_MERGE, 1'b0, 16'd0, 16'd0, 32'd0,
          8'd1, 1'b0, stma_pkg::ST_OK},
        '{ROW_WORD, stma_pkg::CMD_CLEAR, 1'b0, 16'd0, 16'd0, 32'd0,
          8'd1, 1'b1, stma_pkg::ST_OK},
        '{ROW_WORD, stma_pkg::CMD_LOAD_FIRST, 1'b0, 16'd3, 16'd3, 32'd1,
          8'd16, 1'b1, stma_pkg::ST_OK},
        '{ROW_WORD, stma_pkg::CMD_LOAD_FIRST, 1'b0, 16'd3, 16'd3, 32'd7,
          8'd1, 1'b1, stma_pkg::ST_FULL},
        '{ROW_WORD, stma_pkg::CMD_LOAD_FIRST, 1'b0, 16'd65535, 16'd65535, 32'd7,
          8'd1, 1'b1, stma_pkg::ST_RANGE},
        '{ROW_WORD, stma_pkg::CMD_MERGE, 1'b0, 16'd0, 16'd0, 32'd0,
          8'd1, 1'b0, stma_pkg::ST_OK},
        '{ROW_REG, stma_pkg::CMD_CLEAR, stma_pkg::REG_ROW_COUNT, 16'd0, 16'd0, 32'd0,
          8'd1, 1'b0, stma_pkg::ST_OK},
        '{ROW_WORD, stma_pkg::CMD_LOAD_SECOND, 1'b0, 16'd0, 16'd0, 32'd1,
          8'd1, 1'b1, stma_pkg::ST_RANGE},
        '{ROW_REG, stma_pkg::CMD_CLEAR, stma_pkg::REG_ROW_COUNT, 16'd0, 16'd0, 32'd65535,
          8'd1, 1'b0, stma_pkg::ST_OK},
        '{ROW_REG, stma_pkg::CMD_CLEAR, stma_pkg::REG_COLUMN_COUNT, 16'd0, 16'd0, 32'd0,
          8'd1, 1'b0, stma_pkg::ST_OK},
        '{ROW_WORD, stma_pkg::CMD_LOAD_SECOND, 1'b0, 16'd0, 16'd0, 32'd1,
          8'd1, 1'b1, stma_pkg::ST_RANGE},
        '{ROW_REG, stma_pkg::CMD_CLEAR, stma_pkg::REG_COLUMN_COUNT, 16'd0, 16'd0,
          32'd65535, 8'd1, 1'b0, stma_pkg::ST_OK},
        '{ROW_WORD, stma_pkg::CMD_CLEAR, 1'b0, 16'd0, 16'd0, 32'd0,
          8'd1, 1'b1, stma_pkg::ST_OK}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [stma_pkg::ADDR_W-1:0]   paddr;
    logic [stma_pkg::DATA_W-1:0]   pwdata;
    logic [stma_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    stma_item_if   item_bus ();
    stma_result_if result_bus ();

    sparse_triplet_merge_add_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_bus),
        .result  (result_bus)
    );

    // Local copy of the list state and the count registers
    stma_pkg::entry_t list_copy [0:1][0:stma_pkg::MAX_ENTRIES-1];
    int               list_fill [0:1];
    logic [15:0]      rows_cfg;
    logic [15:0]      cols_cfg;

    result_word_t     step_words [$];
    result_word_t     owed_words [$];
    stma_pkg::entry_t batch [0:1][0:BATCH_MAX-1];

    int send_idle_pct;
    int recv_stall_pct;
    int words_sent;
    int merges_sent;
    int words_checked;
    int bad_words;
    int reg_writes;

    always #5 clk = ~clk;

    // Work out the result words of one accepted input word
    task automatic predict_merge_add(input logic [1:0] cmd, input logic [15:0] r,
                                     input logic [15:0] c, input logic [31:0] v);
        int               a;
        int               b;
        int               side;
        logic [2:0]       st;
        stma_pkg::entry_t ea;
        stma_pkg::entry_t eb;
        stma_pkg::entry_t pick;
        logic [32:0]      total;
        bit               emit;
        step_words.delete();
        case (cmd)
            stma_pkg::CMD_CLEAR:
            begin
                list_fill[0] = 0;
                list_fill[1] = 0;
                step_words.push_back('{stma_pkg::ST_OK, 16'd0, 16'd0, 33'd0, 1'b1});
            end
            stma_pkg::CMD_LOAD_FIRST, stma_pkg::CMD_LOAD_SECOND:
            begin
                side = (cmd == stma_pkg::CMD_LOAD_SECOND) ? 1 : 0;
                if (r >= rows_cfg || c >= cols_cfg)
                    st = stma_pkg::ST_RANGE;
                else if (list_fill[side] >= stma_pkg::MAX_ENTRIES)
                    st = stma_pkg::ST_FULL;
                else
                begin
                    st = stma_pkg::ST_OK;
                    list_copy[side][list_fill[side]] = '{row: r, col: c, val: v};
                    list_fill[side]++;
                end
                step_words.push_back('{st, 16'd0, 16'd0, 33'd0, 1'b1});
            end
            default:
            begin
                a = 0;
                b = 0;
                // Walk both heads in (row, column) order; sum on a tie
                while (a < list_fill[0] || b < list_fill[1])
                begin
                    emit = 1'b1;
                    if (a < list_fill[0] && b < list_fill[1])
                    begin
                        ea = list_copy[0][a];
                        eb = list_copy[1][b];
                        if ({ea.row, ea.col} > {eb.row, eb.col})
                        begin
                            pick  = eb;
                            total = {eb.val[31], eb.val};
                            b++;
                        end
                        else if ({ea.row, ea.col} < {eb.row, eb.col})
                        begin
                            pick  = ea;
                            total = {ea.val[31], ea.val};
                            a++;
                        end
                        else
                        begin
                            pick  = ea;
                            total = {ea.val[31], ea.val} + {eb.val[31], eb.val};
                            emit  = (total != 33'd0);
                            a++;
                            b++;
                        end
                    end
                    else if (a < list_fill[0])
                    begin
                        pick  = list_copy[0][a];
                        total = {pick.val[31], pick.val};
                        a++;
                    end
                    else
                    begin
                        pick  = list_copy[1][b];
                        total = {pick.val[31], pick.val};
                        b++;
                    end
                    if (emit)
                        step_words.push_back('{stma_pkg::ST_SUM, pick.row, pick.col,
                                               total, 1'b0});
                end
                if (step_words.size() == 0)
                    step_words.push_back('{stma_pkg::ST_EMPTY, 16'd0, 16'd0, 33'd0, 1'b1});
                else
                    step_words[step_words.size()-1].last = 1'b1;
            end
        endcase
    endtask

    // Offer one input word, hold it until accepted, then queue its results
    task automatic send_word(input logic [1:0] cmd, input logic [15:0] r,
                             input logic [15:0] c, input logic [31:0] v,
                             input bit typed, input logic [2:0] typed_status);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(negedge clk);
        end
        item_bus.valid        <= 1'b1;
        item_bus.command      <= cmd;
        item_bus.row_index    <= r;
        item_bus.column_index <= c;
        item_bus.entry_value  <= v;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        predict_merge_add(cmd, r, c, v);
        if (typed)
            owed_words.push_back('{typed_status, 16'd0, 16'd0, 33'd0, 1'b1});
        else
            foreach (step_words[i])
                owed_words.push_back(step_words[i]);
        words_sent++;
        if (cmd == stma_pkg::CMD_MERGE)
            merges_sent++;
    endtask

    // Drop valid and wait until every owed word has come back
    task automatic drain_results();
        @(negedge clk);
        item_bus.valid <= 1'b0;
        while (owed_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_count(input logic reg_sel, input logic [15:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {16'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (reg_sel == stma_pkg::REG_ROW_COUNT)
            rows_cfg = value;
        else
            cols_cfg = value;
        reg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'($urandom_range(20)) - 32'd10;
            default: return $urandom;
        endcase
    endfunction

    // Insertion sort of one batch by (row, column)
    task automatic sort_batch(input int side, input int n);
        stma_pkg::entry_t hold;
        int               j;
        for (int i = 1; i < n; i++)
        begin
            hold = batch[side][i];
            j    = i - 1;
            while (j >= 0 &&
                   {batch[side][j].row, batch[side][j].col} > {hold.row, hold.col})
            begin
                batch[side][j+1] = batch[side][j];
                j--;
            end
            batch[side][j+1] = hold;
        end
    endtask

    // Well-formed run: optional clear, two sorted lists with overlaps, merge
    task automatic run_sum_sequence();
        int n [0:1];
        int p;
        if ($urandom_range(99) < 80)
            send_word(stma_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom), $urandom,
                      1'b0, stma_pkg::ST_OK);
        for (int s = 0; s < 2; s++)
            n[s] = ($urandom_range(9) == 0) ? $urandom_range(18, 14) : $urandom_range(8);
        for (int j = 0; j < n[0]; j++)
            batch[0][j] = '{row: 16'($urandom_range(int'(rows_cfg) - 1)),
                            col: 16'($urandom_range(int'(cols_cfg) - 1)),
                            val: pick_value()};
        sort_batch(0, n[0]);
        for (int j = 0; j < n[1]; j++)
        begin
            if (n[0] > 0 && $urandom_range(1) == 1)
            begin
                p = $urandom_range(n[0] - 1);
                batch[1][j] = batch[0][p];
                // Cancel the partner to hit the dropped-zero path
                if ($urandom_range(99) < 30)
                    batch[1][j].val = -batch[0][p].val;
                else
                    batch[1][j].val = pick_value();
            end
            else
                batch[1][j] = '{row: 16'($urandom_range(int'(rows_cfg) - 1)),
                                col: 16'($urandom_range(int'(cols_cfg) - 1)),
                                val: pick_value()};
        end
        sort_batch(1, n[1]);
        for (int j = 0; j < n[0]; j++)
            send_word(stma_pkg::CMD_LOAD_FIRST, batch[0][j].row, batch[0][j].col,
                      batch[0][j].val, 1'b0, stma_pkg::ST_OK);
        for (int j = 0; j < n[1]; j++)
            send_word(stma_pkg::CMD_LOAD_SECOND, batch[1][j].row, batch[1][j].col,
                      batch[1][j].val, 1'b0, stma_pkg::ST_OK);
        send_word(stma_pkg::CMD_MERGE, 16'($urandom), 16'($urandom), $urandom,
                  1'b0, stma_pkg::ST_OK);
        if ($urandom_range(9) == 0)
            send_word(stma_pkg::CMD_MERGE, 16'd0, 16'd0, 32'd0, 1'b0, stma_pkg::ST_OK);
    endtask

    // Noise: any command, indices in or out of range, unsorted order
    task automatic send_noise();
        logic [15:0] r;
        logic [15:0] c;
        r = ($urandom_range(1) == 1) ? 16'($urandom) : 16'($urandom_range(int'(rows_cfg)));
        c = ($urandom_range(1) == 1) ? 16'($urandom) : 16'($urandom_range(int'(cols_cfg)));
        send_word(2'($urandom_range(3)), r, c, pick_value(), 1'b0, stma_pkg::ST_OK);
    endtask

    task automatic log_mismatch(input result_word_t want, input result_word_t got,
                                input bit orphan);
        bad_words++;
        if (bad_words <= 10)
        begin
            if (orphan)
                $display("%0t: unexpected result st=%0d r=%0d c=%0d v=%0d last=%0b",
                         $realtime, got.status, got.row, got.col,
                         $signed(got.value), got.last);
            else
            begin
                $display("%0t: result mismatch exp st=%0d r=%0d c=%0d v=%0d last=%0b",
                         $realtime, want.status, want.row, want.col,
                         $signed(want.value), want.last);
                $display("%0t:                 got st=%0d r=%0d c=%0d v=%0d last=%0b",
                         $realtime, got.status, got.row, got.col,
                         $signed(got.value), got.last);
            end
        end
    endtask

    // Compare each accepted result word with the oldest owed word
    always @(posedge clk)
    begin : result_check
        result_word_t got;
        result_word_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got = '{result_bus.status, result_bus.out_row, result_bus.out_column,
                    result_bus.out_value, result_bus.last};
            words_checked++;
            if (owed_words.size() == 0)
                log_mismatch(got, got, 1'b1);
            else
            begin
                want = owed_words.pop_front();
                if (got.status !== want.status || got.row !== want.row ||
                    got.col !== want.col || got.value !== want.value ||
                    got.last !== want.last)
                    log_mismatch(want, got, 1'b0);
            end
        end
    end

    // Stall the result channel at the phase's rate
    always @(negedge clk)
        result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

    initial
    begin
        #5_000_000;
        $display("sparse_triplet_merge_add_unit_tb NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        int phase_start;
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        item_bus.valid        = 1'b0;
        item_bus.command      = stma_pkg::CMD_CLEAR;
        item_bus.row_index    = '0;
        item_bus.column_index = '0;
        item_bus.entry_value  = '0;
        result_bus.ready      = 1'b0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;
        words_sent            = 0;
        merges_sent           = 0;
        words_checked         = 0;
        bad_words             = 0;
        reg_writes            = 0;
        rows_cfg              = 16'd65535;
        cols_cfg              = 16'd65535;
        list_fill[0]          = 0;
        list_fill[1]          = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (PLAN[i].kind == ROW_REG)
            begin
                drain_results();
                write_count(PLAN[i].reg_sel, PLAN[i].val[15:0]);
            end
            else
                for (int k = 0; k < PLAN[i].reps; k++)
                    send_word(PLAN[i].cmd, PLAN[i].row, PLAN[i].col, PLAN[i].val,
                              PLAN[i].typed, PLAN[i].status);
        end

        // Random phases, each with its own idling and register setting
        for (int ph = 0; ph < 4; ph++)
        begin
            drain_results();
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    write_count(stma_pkg::REG_ROW_COUNT, 16'd65535);
                    write_count(stma_pkg::REG_COLUMN_COUNT, 16'd65535);
                end
                1:
                begin
                    send_idle_pct  = 50;
                    recv_stall_pct = 0;
                    write_count(stma_pkg::REG_ROW_COUNT, 16'd16);
                    write_count(stma_pkg::REG_COLUMN_COUNT, 16'd8);
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 50;
                    write_count(stma_pkg::REG_ROW_COUNT, 16'd1);
                    write_count(stma_pkg::REG_COLUMN_COUNT, 16'd65535);
                end
                default:
                begin
                    send_idle_pct  = 25;
                    recv_stall_pct = 25;
                    write_count(stma_pkg::REG_ROW_COUNT, 16'd300);
                    write_count(stma_pkg::REG_COLUMN_COUNT, 16'd1);
                end
            endcase
            phase_start = words_sent;
            while (words_sent - phase_start < 115)
            begin
                if ($urandom_range(99) < 80)
                    run_sum_sequence();
                else
                    repeat ($urandom_range(3, 1)) send_noise();
            end
        end

        drain_results();
        repeat (20) @(posedge clk);

        $display("Sent %0d input words (%0d merges), checked %0d result words",
                 words_sent, merges_sent, words_checked);
        $display("over %0d register writes and four idling phases; %0d bad words",
                 reg_writes, bad_words);
        if (bad_words == 0 && owed_words.size() == 0)
            $display("sparse_triplet_merge_add_unit_tb OK");
        else
            $display("sparse_triplet_merge_add_unit_tb NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/stma_pkg.sv
hdl/stma_ifs.sv
hdl/stma_list.sv
hdl/sparse_triplet_merge_add_unit.sv
verif/sparse_triplet_merge_add_unit_tb.sv
